### hw/rtl/gsa_pkg.sv
package gsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_AW   = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_AW + 1;
  localparam int GEN_W     = 16;
  localparam int IDX_W     = 16;
  localparam int ID_W      = GEN_W + IDX_W;
  localparam int CFG_W     = 11;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_RANGE   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_t;

  // One slot table entry: occupancy flag and the id handed out.
  typedef struct packed {
    logic            used;
    logic [ID_W-1:0] id;
  } slot_entry_t;

  localparam int SLOT_DW = $bits(slot_entry_t);

  // Clearing sequencer status toward the top level.
  typedef struct packed {
    logic               busy;
    logic [SLOT_AW-1:0] addr;
  } clr_t;

endpackage

### hw/rtl/gsa_ram.sv
module gsa_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [(1 << AW)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/gsa_clear.sv
module gsa_clear (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output gsa_pkg::clr_t clr
);

  logic                        busy_r;
  logic                        busy_nxt;
  logic [gsa_pkg::SLOT_AW-1:0] addr_r;
  logic [gsa_pkg::SLOT_AW-1:0] addr_nxt;

  always_comb begin
    busy_nxt = busy_r;
    addr_nxt = addr_r;
    if (start) begin
      busy_nxt = 1'b1;
      addr_nxt = '0;
    end else if (busy_r) begin
      addr_nxt = addr_r + 1'b1;
      // last entry swept: drop busy
      if (addr_r == {gsa_pkg::SLOT_AW{1'b1}}) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      addr_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign clr.busy = busy_r;
  assign clr.addr = addr_r;

endmodule

### hw/rtl/generational_slot_id_allocator.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_operation, in_conn_id
// out      output     out_valid / out_stall out_status, out_result_id, out_occupied
// cfg      input      cfg_valid / cfg_ready cfg_slot_count
//
// The accept edge issues the slot table and free queue reads; a later edge, once the output
// register is not stalled, applies the read-modify-write and loads the result register.
// in_stall is high while an operation is in flight or clearing runs: one operation at a time.
// After reset and after every slot_count write a clearing pass wipes the slot table while
// inputs are stalled (cfg writes are always taken).
// A stalled result holds in the output register and the pending operation waits.
module generational_slot_id_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [gsa_pkg::ID_W-1:0]    in_conn_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [gsa_pkg::ID_W-1:0]    out_result_id,
  output logic                        out_occupied,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gsa_pkg::CFG_W-1:0]   cfg_slot_count
);

  localparam int AW = gsa_pkg::SLOT_AW;
  localparam int CW = gsa_pkg::CNT_W;

  // Control state
  logic          s1_valid_r, s1_valid_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic          head_wrap_r, head_wrap_nxt;
  logic [CW-1:0] queued_r, queued_nxt;
  logic [CW-1:0] batch_r, batch_nxt;
  logic [gsa_pkg::GEN_W-1:0] gen_r, gen_nxt;

  // Payload registers
  gsa_pkg::op_t              s1_op_r;
  logic [gsa_pkg::ID_W-1:0]  s1_id_r;
  gsa_pkg::status_t          res_status_r, res_status_nxt;
  logic [gsa_pkg::ID_W-1:0]  res_id_r, res_id_nxt;
  logic                      res_occ_r, res_occ_nxt;

  logic          in_acc;
  logic          cfg_wr;
  logic          done;
  logic [CW-1:0] n_new;

  gsa_pkg::clr_t clr;

  // Memory ports
  logic                         slot_we;
  logic [AW-1:0]                slot_waddr;
  gsa_pkg::slot_entry_t         slot_wdata;
  logic [gsa_pkg::SLOT_DW-1:0]  slot_rdata;
  gsa_pkg::slot_entry_t         slot_rd;
  logic                         q_we;
  logic [AW-1:0]                q_rdata;

  // Stage-B working values
  logic [gsa_pkg::IDX_W-1:0] slot16;
  logic                      in_range;
  logic [CW-1:0]             batch_eff;
  logic [gsa_pkg::GEN_W-1:0] gen_eff;
  logic [AW-1:0]             alloc_idx;
  logic                      head_fresh;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready;
  assign in_stall  = s1_valid_r | clr.busy;
  assign in_acc    = in_valid & ~in_stall;
  assign done      = s1_valid_r & (~out_valid_r | ~out_stall);

  // Saturate the written count to the table size.
  assign n_new = (cfg_slot_count > CW'(gsa_pkg::MAX_SLOTS)) ? CW'(gsa_pkg::MAX_SLOTS)
                                                           : CW'(cfg_slot_count);

  gsa_clear u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .clr   (clr)
  );

  // Slot table: {used, id} per slot, read at the accepted id's slot.
  gsa_ram #(
    .DW (gsa_pkg::SLOT_DW),
    .AW (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (in_acc),
    .raddr (in_conn_id[AW-1:0]),
    .rdata (slot_rdata)
  );

  assign slot_rd = gsa_pkg::slot_entry_t'(slot_rdata);

  // Free queue: read at head on accept, appended at tail on a free.
  gsa_ram #(
    .DW (AW),
    .AW (AW)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail_r),
    .wdata (s1_id_r[AW-1:0]),
    .re    (in_acc),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  assign slot16   = s1_id_r[gsa_pkg::IDX_W-1:0];
  assign in_range = slot16 < gsa_pkg::IDX_W'(n_r);

  // On its first lap the head uses its position as the index (entry i stands for i)
  // for positions below n; every other position was written by a free.
  assign head_fresh = ~head_wrap_r & ({1'b0, head_r} < n_r);
  assign alloc_idx  = head_fresh ? head_r : q_rdata;

  // A spent batch rolls over to the indices freed since, with a new generation.
  assign batch_eff = (batch_r == '0) ? queued_r : batch_r;
  assign gen_eff   = (batch_r == '0) ? gen_r + 1'b1 : gen_r;

  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    n_nxt          = n_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    head_wrap_nxt  = head_wrap_r;
    queued_nxt     = queued_r;
    batch_nxt      = batch_r;
    gen_nxt        = gen_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_occ_nxt    = res_occ_r;
    slot_we        = 1'b0;
    slot_waddr     = clr.addr;
    slot_wdata     = '0;
    q_we           = 1'b0;

    out_valid_nxt = out_valid_r & out_stall;

    if (clr.busy) begin
      // sweep: mark each slot unused
      slot_we = 1'b1;
    end

    if (done) begin
      s1_valid_nxt   = 1'b0;
      out_valid_nxt  = 1'b1;
      res_status_nxt = gsa_pkg::ST_OK;
      res_id_nxt     = '0;
      res_occ_nxt    = 1'b0;
      case (s1_op_r)
        gsa_pkg::OP_ALLOC: begin
          batch_nxt = batch_eff;
          gen_nxt   = gen_eff;
          if (batch_eff == '0) begin
            res_status_nxt = gsa_pkg::ST_NO_SLOT;
          end else begin
            head_nxt   = head_r + 1'b1;
            batch_nxt  = batch_eff - 1'b1;
            queued_nxt = queued_r - 1'b1;
            if (head_r == {AW{1'b1}}) begin
              head_wrap_nxt = 1'b1;
            end
            res_id_nxt = {gen_eff, (gsa_pkg::IDX_W - AW)'(0), alloc_idx};
            slot_we         = 1'b1;
            slot_waddr      = alloc_idx;
            slot_wdata.used = 1'b1;
            slot_wdata.id   = {gen_eff, (gsa_pkg::IDX_W - AW)'(0), alloc_idx};
          end
        end
        gsa_pkg::OP_FREE: begin
          if (!in_range) begin
            res_status_nxt = gsa_pkg::ST_RANGE;
          end else if (!slot_rd.used) begin
            res_status_nxt = gsa_pkg::ST_UNUSED;
          end else begin
            // release the slot and append its index to the queue
            slot_we    = 1'b1;
            slot_waddr = s1_id_r[AW-1:0];
            q_we       = 1'b1;
            tail_nxt   = tail_r + 1'b1;
            queued_nxt = queued_r + 1'b1;
          end
        end
        gsa_pkg::OP_LOOKUP: begin
          if (!in_range) begin
            res_status_nxt = gsa_pkg::ST_RANGE;
          end else if (slot_rd.used) begin
            res_occ_nxt = 1'b1;
            res_id_nxt  = slot_rd.id;
          end
        end
        default: begin
        end
      endcase
    end

    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end

    // Restart with the new count; the clearing pass starts alongside.
    if (cfg_wr) begin
      n_nxt         = n_new;
      head_nxt      = '0;
      tail_nxt      = n_new[AW-1:0];
      head_wrap_nxt = 1'b0;
      queued_nxt    = n_new;
      batch_nxt     = n_new;
      gen_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= CW'(gsa_pkg::MAX_SLOTS);
      head_r      <= '0;
      tail_r      <= AW'(gsa_pkg::MAX_SLOTS);
      head_wrap_r <= 1'b0;
      queued_r    <= CW'(gsa_pkg::MAX_SLOTS);
      batch_r     <= CW'(gsa_pkg::MAX_SLOTS);
      gen_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      head_wrap_r <= head_wrap_nxt;
      queued_r    <= queued_nxt;
      batch_r     <= batch_nxt;
      gen_r       <= gen_nxt;
    end
  end

  // Payload: capture on accept, result on completion.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r <= gsa_pkg::op_t'(in_operation);
      s1_id_r <= in_conn_id;
    end
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_occ_r    <= res_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = res_status_r;
  assign out_result_id = res_id_r;
  assign out_occupied  = res_occ_r;

endmodule
